>>> hw/rtl/plsa_pkg.sv
// plsa_pkg: shared types, codes and sizes for the pinned LRU slot allocator.
// Used by plsa_ctrl, plsa_dp and pinned_lru_slot_allocator; no dependencies.
package plsa_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int SEQ_W      = 32;
  localparam int FREQ_W     = 24;
  localparam int TOTAL_W    = 32;
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 2;
  localparam int PCOUNT_W   = 8;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_REQUEST    = 3'd0,
    OP_SET_PINNED = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_RESET_DYN  = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_NOT_PINNED = 2'd2,
    ST_NO_SLOT    = 2'd3
  } st_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIXED   = 2'd0,
    MODE_DYNAMIC = 2'd1,
    MODE_HYBRID  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_MODE    = 2'd0,
    CFG_PINNED_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_EVICT,
    S_APPLY,
    S_COUNT,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;
    logic ptr_bound;
    logic ptr_zero;
    logic ptr_inc;
    logic pick_ptr;
    logic pick_idx;
    logic eval_oldest;
    logic set_evicted;
    logic set_status;
    st_t  status_code;
    logic reject_inc;
    logic place;
    logic clear_one;
    logic clear_dyn;
    logic cnt_clr;
    logic cnt_acc;
    logic out_load;
  } plsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             bound_full;
    logic             ptr_busy;
    logic             ptr_last;
    logic             idx_oob;
    logic             idx_pinned;
    logic             out_free;
  } plsa_sts_t;

endpackage

>>> hw/rtl/plsa_ctrl.sv
// plsa_ctrl: sequencer for one transaction at a time (decode, scans, update, count).
// Depends on plsa_pkg; drives plsa_dp through plsa_cmd_t.
module plsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plsa_pkg::plsa_sts_t sts,
  output plsa_pkg::plsa_cmd_t cmd
);
  import plsa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status_code = ST_OK;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.ptr_zero = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_nxt    = S_COUNT;
        case (sts.op)
          OP_REQUEST: begin
            if (sts.bound_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NO_SLOT;
              cmd.reject_inc  = 1'b1;
            end else begin
              cmd.ptr_zero  = 1'b0;
              cmd.cnt_clr   = 1'b0;
              cmd.ptr_bound = 1'b1;
              state_nxt     = S_SEARCH;
            end
          end
          OP_SET_PINNED: begin
            if (sts.idx_oob) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else if (!sts.idx_pinned) begin
              cmd.pick_idx    = 1'b1;
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_PINNED;
            end else begin
              cmd.pick_idx = 1'b1;
              cmd.ptr_zero = 1'b0;
              cmd.cnt_clr  = 1'b0;
              state_nxt    = S_APPLY;
            end
          end
          OP_RELEASE: begin
            if (sts.idx_oob) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.pick_idx = 1'b1;
              cmd.ptr_zero = 1'b0;
              cmd.cnt_clr  = 1'b0;
              state_nxt    = S_APPLY;
            end
          end
          OP_RESET_DYN: begin
            cmd.clear_dyn = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        if (!sts.ptr_busy) begin
          cmd.pick_ptr = 1'b1;
          state_nxt    = S_APPLY;
        end else if (sts.ptr_last) begin
          cmd.ptr_bound = 1'b1;
          state_nxt     = S_EVICT;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_EVICT: begin
        cmd.eval_oldest = 1'b1;
        if (sts.ptr_last) begin
          cmd.set_evicted = 1'b1;
          state_nxt       = S_APPLY;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_APPLY: begin
        if (sts.op == OP_RELEASE) begin
          cmd.clear_one = 1'b1;
        end else begin
          cmd.place = 1'b1;
        end
        cmd.ptr_zero = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_nxt    = S_COUNT;
      end
      S_COUNT: begin
        cmd.cnt_acc = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/plsa_dp.sv
// plsa_dp: slot bank state, scan pointer, oldest-stamp search, counters, totals,
// configuration registers and result register. Depends on plsa_pkg.
module plsa_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  plsa_pkg::plsa_cmd_t              cmd,
  output plsa_pkg::plsa_sts_t              sts,
  input  logic [plsa_pkg::CMD_W-1:0]       in_command,
  input  logic [plsa_pkg::IDX_W-1:0]       in_slot_index,
  input  logic [plsa_pkg::FREQ_W-1:0]      in_frequency,
  input  logic                             cfg_we,
  input  logic [plsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [plsa_pkg::STATUS_W-1:0]    out_status,
  output logic [plsa_pkg::SLOT_W-1:0]      out_chosen_slot,
  output logic                             out_evicted,
  output logic [plsa_pkg::CNT_W-1:0]       out_used_count,
  output logic [plsa_pkg::CNT_W-1:0]       out_free_dynamic_count,
  output logic [plsa_pkg::TOTAL_W-1:0]     out_reject_total,
  output logic [plsa_pkg::TOTAL_W-1:0]     out_evict_total
);
  import plsa_pkg::*;

  logic [CMD_W-1:0]    item_cmd_r;
  logic [IDX_W-1:0]    item_idx_r;
  logic [FREQ_W-1:0]   item_freq_r;
  logic [SLOT_W-1:0]   ptr_r;
  logic [SLOT_W-1:0]   pick_r;
  logic [SEQ_W-1:0]    best_seq_r;
  logic                best_vld_r;
  logic                evicted_r;
  st_t                 status_r;
  logic [CNT_W-1:0]    used_r;
  logic [CNT_W-1:0]    free_r;
  logic [SEQ_W-1:0]    next_seq_r;
  logic [TOTAL_W-1:0]  rejects_r;
  logic [TOTAL_W-1:0]  evicts_r;
  logic [SLOT_COUNT-1:0] busy_r;
  logic [MODE_W-1:0]   mode_r;
  logic [PCOUNT_W-1:0] pcount_r;
  logic [CNT_W-1:0]    bound_r;
  logic [SEQ_W-1:0]    seq_mem_r  [SLOT_COUNT];
  logic [FREQ_W-1:0]   freq_mem_r [SLOT_COUNT];

  logic                out_valid_r;
  st_t                 out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_evicted_r;
  logic [CNT_W-1:0]    out_used_r;
  logic [CNT_W-1:0]    out_free_r;
  logic [TOTAL_W-1:0]  out_rej_r;
  logic [TOTAL_W-1:0]  out_evt_r;

  logic                cfg_hit;
  logic [MODE_W-1:0]   mode_nxt;
  logic [PCOUNT_W-1:0] pcount_nxt;
  logic [CNT_W-1:0]    bound_nxt;
  logic [SEQ_W-1:0]    ptr_seq;
  logic                ptr_unpinned;
  logic [SLOT_COUNT-1:0] dyn_mask;

  // configuration decode and pinned bound
  always_comb begin
    cfg_hit    = 1'b0;
    mode_nxt   = mode_r;
    pcount_nxt = pcount_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BANK_MODE: begin
          cfg_hit  = 1'b1;
          mode_nxt = cfg_data[MODE_W-1:0];
        end
        CFG_PINNED_COUNT: begin
          cfg_hit    = 1'b1;
          pcount_nxt = cfg_data[PCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
    unique case (mode_nxt)
      MODE_FIXED:   bound_nxt = CNT_W'(SLOT_COUNT);
      MODE_DYNAMIC: bound_nxt = '0;
      default: begin
        if (PCOUNT_W'(SLOT_COUNT) < pcount_nxt) begin
          bound_nxt = CNT_W'(SLOT_COUNT);
        end else begin
          bound_nxt = CNT_W'(pcount_nxt);
        end
      end
    endcase
  end

  always_comb begin
    ptr_seq      = seq_mem_r[ptr_r];
    ptr_unpinned = ({1'b0, ptr_r} >= bound_r);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      dyn_mask[i] = (CNT_W'(i) >= bound_r);
    end
  end

  always_comb begin
    sts.op         = item_cmd_r;
    sts.bound_full = (bound_r == CNT_W'(SLOT_COUNT));
    sts.ptr_busy   = busy_r[ptr_r];
    sts.ptr_last   = (ptr_r == SLOT_W'(SLOT_COUNT - 1));
    sts.idx_oob    = (item_idx_r >= IDX_W'(SLOT_COUNT));
    sts.idx_pinned = ({{(IDX_W-CNT_W){1'b0}}, bound_r} > item_idx_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // control and bank state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_FIXED;
      pcount_r   <= '0;
      bound_r    <= CNT_W'(SLOT_COUNT);
      busy_r     <= '0;
      next_seq_r <= SEQ_W'(1);
      rejects_r  <= '0;
      evicts_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        mode_r     <= mode_nxt;
        pcount_r   <= pcount_nxt;
        bound_r    <= bound_nxt;
        busy_r     <= '0;
        next_seq_r <= SEQ_W'(1);
        rejects_r  <= '0;
        evicts_r   <= '0;
      end else begin
        if (cmd.reject_inc) begin
          rejects_r <= rejects_r + TOTAL_W'(1);
        end
        if (cmd.place) begin
          busy_r[pick_r] <= 1'b1;
          next_seq_r     <= next_seq_r + SEQ_W'(1);
          if (evicted_r) begin
            evicts_r <= evicts_r + TOTAL_W'(1);
          end
        end
        if (cmd.clear_one) begin
          busy_r[pick_r] <= 1'b0;
        end
        if (cmd.clear_dyn) begin
          busy_r <= busy_r & ~dyn_mask;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_cmd_r  <= in_command;
      item_idx_r  <= in_slot_index;
      item_freq_r <= in_frequency;
      pick_r      <= '0;
      evicted_r   <= 1'b0;
      status_r    <= ST_OK;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.set_evicted) begin
      evicted_r <= 1'b1;
    end
    if (cmd.pick_idx) begin
      pick_r <= item_idx_r[SLOT_W-1:0];
    end
    if (cmd.pick_ptr) begin
      pick_r <= ptr_r;
    end
    if (cmd.ptr_bound) begin
      ptr_r      <= bound_r[SLOT_W-1:0];
      best_vld_r <= 1'b0;
    end else if (cmd.ptr_zero) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + SLOT_W'(1);
    end
    if (cmd.eval_oldest && (!best_vld_r || (ptr_seq < best_seq_r))) begin
      best_seq_r <= ptr_seq;
      best_vld_r <= 1'b1;
      pick_r     <= ptr_r;
    end
    if (cmd.place) begin
      seq_mem_r[pick_r]  <= next_seq_r;
      freq_mem_r[pick_r] <= item_freq_r;
    end
    if (cmd.cnt_clr) begin
      used_r <= '0;
      free_r <= '0;
    end else if (cmd.cnt_acc) begin
      if (busy_r[ptr_r]) begin
        used_r <= used_r + CNT_W'(1);
      end else if (ptr_unpinned) begin
        free_r <= free_r + CNT_W'(1);
      end
    end
    if (cmd.out_load) begin
      out_status_r  <= status_r;
      out_slot_r    <= pick_r;
      out_evicted_r <= evicted_r;
      out_used_r    <= used_r;
      out_free_r    <= free_r;
      out_rej_r     <= rejects_r;
      out_evt_r     <= evicts_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_chosen_slot        = out_slot_r;
  assign out_evicted            = out_evicted_r;
  assign out_used_count         = out_used_r;
  assign out_free_dynamic_count = out_free_r;
  assign out_reject_total       = out_rej_r;
  assign out_evict_total        = out_evt_r;

endmodule

>>> hw/rtl/pinned_lru_slot_allocator.sv
// Top level of the pinned LRU slot allocator: plsa_ctrl sequences plsa_dp.
// Depends on plsa_pkg, plsa_ctrl and plsa_dp.
//
// Usage: commands enter on the in_ channel (valid/ready), one result per
// transaction leaves on the out_ channel (valid/ready). Bank mode and pinned
// count are written through the cfg_ channel (index 0 mode, 1 pinned count;
// other indexes are ignored); a write clears every slot, the sequence stamp
// and both totals. cfg_ready is always high; write only while idle.
// One transaction is in work at a time. The bank is walked one slot per
// cycle: a request scans the unpinned slots for a free one, then for the
// oldest stamp if all are busy, and every command ends with a pass over
// all slots that counts used and free slots. The next transaction can be
// taken in the cycle after the result is loaded. The result sits in its own
// register, so the next transaction is taken while it waits; if out_ready
// stays low, the following result is held back until the register empties.
// Synchronous active-low reset gives bank mode 0 (all pinned), an empty bank
// and zero totals; no clearing pass is needed.
module pinned_lru_slot_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [plsa_pkg::CMD_W-1:0]       in_command,
  input  logic [plsa_pkg::IDX_W-1:0]       in_slot_index,
  input  logic [plsa_pkg::FREQ_W-1:0]      in_frequency,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [plsa_pkg::STATUS_W-1:0]    out_status,
  output logic [plsa_pkg::SLOT_W-1:0]      out_chosen_slot,
  output logic                             out_evicted,
  output logic [plsa_pkg::CNT_W-1:0]       out_used_count,
  output logic [plsa_pkg::CNT_W-1:0]       out_free_dynamic_count,
  output logic [plsa_pkg::TOTAL_W-1:0]     out_reject_total,
  output logic [plsa_pkg::TOTAL_W-1:0]     out_evict_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import plsa_pkg::*;

  plsa_cmd_t cmd;
  plsa_sts_t sts;

  assign cfg_ready = 1'b1;

  plsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plsa_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_command             (in_command),
    .in_slot_index          (in_slot_index),
    .in_frequency           (in_frequency),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_chosen_slot        (out_chosen_slot),
    .out_evicted            (out_evicted),
    .out_used_count         (out_used_count),
    .out_free_dynamic_count (out_free_dynamic_count),
    .out_reject_total       (out_reject_total),
    .out_evict_total        (out_evict_total)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in work");

  a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_used_count + out_free_dynamic_count) <= CNT_W'(SLOT_COUNT)))
    else $error("used plus free slots exceed the bank size");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_SLOT)) |-> (out_chosen_slot == '0 && !out_evicted))
    else $error("rejected request reports a slot or an eviction");

  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_status == ST_OK && out_evict_total != '0))
    else $error("eviction reported without ok status or evict count");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for pinned_lru_slot_allocator: a scoreboard class predicts
// each result from the accepted commands and the bank settings. Needs plsa_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plsa_pkg::*;

  localparam int CMD_MAX      = (1 << CMD_W) - 1;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 123;
  localparam int IDLE_GUARD   = 8;
  localparam int FINAL_WAIT   = 80;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    st_t                status;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   free_dyn;
    logic [TOTAL_W-1:0] rejects;
    logic [TOTAL_W-1:0] evicts;
  } slot_outcome_t;

  class slot_alloc_scoreboard;
    bit                  busy  [SLOT_COUNT];
    logic [SEQ_W-1:0]    stamp [SLOT_COUNT];
    logic [FREQ_W-1:0]   code  [SLOT_COUNT];
    logic [SEQ_W-1:0]    next_stamp;
    logic [TOTAL_W-1:0]  rejected;
    logic [TOTAL_W-1:0]  evictions;
    logic [MODE_W-1:0]   mode;
    logic [PCOUNT_W-1:0] pcount;
    int                  pinned_bound;
    slot_outcome_t       outcomes_q[$];
    int                  mismatches;
    int                  checked;
    int                  evict_seen;
    int                  reject_seen;

    function new();
      mode   = MODE_FIXED;
      pcount = '0;
      reinit();
    endfunction

    function void reinit();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        busy[i]  = 1'b0;
        stamp[i] = '0;
        code[i]  = '0;
      end
      next_stamp = 1;
      rejected   = '0;
      evictions  = '0;
      if (mode == MODE_FIXED) begin
        pinned_bound = SLOT_COUNT;
      end else if (mode == MODE_DYNAMIC) begin
        pinned_bound = 0;
      end else begin
        pinned_bound = (pcount <= SLOT_COUNT) ? int'(pcount) : SLOT_COUNT;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BANK_MODE) begin
        mode = data[MODE_W-1:0];
        reinit();
      end else if (idx == CFG_PINNED_COUNT) begin
        pcount = data[PCOUNT_W-1:0];
        reinit();
      end
    endfunction

    function void place_slot(int s, logic [FREQ_W-1:0] f);
      busy[s]    = 1'b1;
      code[s]    = f;
      stamp[s]   = next_stamp;
      next_stamp = next_stamp + 1;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic [FREQ_W-1:0] f);
      slot_outcome_t o;
      int            pick;
      bit            found;
      o.status   = ST_OK;
      o.slot     = '0;
      o.evicted  = 1'b0;
      o.used     = '0;
      o.free_dyn = '0;
      case (cmd)
        OP_REQUEST: begin
          pick  = SLOT_COUNT;
          found = 1'b0;
          for (int i = pinned_bound; i < SLOT_COUNT; i++) begin
            if (!found && !busy[i]) begin
              pick  = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            // oldest stamp wins, lowest index on a tie
            for (int i = pinned_bound; i < SLOT_COUNT; i++) begin
              if (!found || stamp[i] < stamp[pick]) begin
                pick  = i;
                found = 1'b1;
              end
            end
            o.evicted = found;
          end
          if (!found) begin
            rejected = rejected + 1;
            o.status = ST_NO_SLOT;
            reject_seen++;
          end else begin
            if (o.evicted) begin
              evictions = evictions + 1;
              evict_seen++;
            end
            place_slot(pick, f);
            o.slot = pick[SLOT_W-1:0];
          end
        end
        OP_SET_PINNED: begin
          if (idx >= SLOT_COUNT) begin
            o.status = ST_RANGE;
          end else if (idx >= pinned_bound) begin
            o.status = ST_NOT_PINNED;
            o.slot   = idx[SLOT_W-1:0];
          end else begin
            place_slot(int'(idx), f);
            o.slot = idx[SLOT_W-1:0];
          end
        end
        OP_RELEASE: begin
          if (idx >= SLOT_COUNT) begin
            o.status = ST_RANGE;
          end else begin
            busy[idx]  = 1'b0;
            stamp[idx] = '0;
            code[idx]  = '0;
            o.slot     = idx[SLOT_W-1:0];
          end
        end
        OP_RESET_DYN: begin
          for (int i = pinned_bound; i < SLOT_COUNT; i++) begin
            busy[i]  = 1'b0;
            stamp[i] = '0;
            code[i]  = '0;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (busy[i]) begin
          o.used = o.used + CNT_W'(1);
        end else if (i >= pinned_bound) begin
          o.free_dyn = o.free_dyn + CNT_W'(1);
        end
      end
      o.rejects = rejected;
      o.evicts  = evictions;
      outcomes_q.push_back(o);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_outcome(slot_outcome_t got);
      slot_outcome_t want;
      if (outcomes_q.size() == 0) begin
        report($sformatf("result with no command pending, status %0d slot %0d",
                         got.status, got.slot));
      end else begin
        want = outcomes_q.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("result %0d status %0d, want %0d", checked, got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("result %0d chosen_slot %0d, want %0d", checked, got.slot, want.slot));
        if (got.evicted !== want.evicted)
          report($sformatf("result %0d evicted %0b, want %0b", checked, got.evicted,
                           want.evicted));
        if (got.used !== want.used)
          report($sformatf("result %0d used_count %0d, want %0d", checked, got.used, want.used));
        if (got.free_dyn !== want.free_dyn)
          report($sformatf("result %0d free_dynamic_count %0d, want %0d", checked,
                           got.free_dyn, want.free_dyn));
        if (got.rejects !== want.rejects)
          report($sformatf("result %0d reject_total %0d, want %0d", checked, got.rejects,
                           want.rejects));
        if (got.evicts !== want.evicts)
          report($sformatf("result %0d evict_total %0d, want %0d", checked, got.evicts,
                           want.evicts));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command;
  logic [IDX_W-1:0]      in_slot_index;
  logic [FREQ_W-1:0]     in_frequency;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_W-1:0]     out_chosen_slot;
  logic                  out_evicted;
  logic [CNT_W-1:0]      out_used_count;
  logic [CNT_W-1:0]      out_free_dynamic_count;
  logic [TOTAL_W-1:0]    out_reject_total;
  logic [TOTAL_W-1:0]    out_evict_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_alloc_scoreboard sb = new();
  int items_sent    = 0;
  int hold_asks     = 0;
  int holds_served  = 0;
  int cycle_count   = 0;

  pinned_lru_slot_allocator dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (in_command),
    .in_slot_index          (in_slot_index),
    .in_frequency           (in_frequency),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_chosen_slot        (out_chosen_slot),
    .out_evicted            (out_evicted),
    .out_used_count         (out_used_count),
    .out_free_dynamic_count (out_free_dynamic_count),
    .out_reject_total       (out_reject_total),
    .out_evict_total        (out_evict_total),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
               sb.outcomes_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    slot_outcome_t got;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      got.status   = st_t'(out_status);
      got.slot     = out_chosen_slot;
      got.evicted  = out_evicted;
      got.used     = out_used_count;
      got.free_dyn = out_free_dynamic_count;
      got.rejects  = out_reject_total;
      got.evicts   = out_evict_total;
      sb.check_outcome(got);
    end
  end

  // result side: changing stall styles, plus long hold-offs on request
  initial begin
    int stall_left;
    int style;
    int style_left;
    stall_left = 0;
    style      = 0;
    style_left = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_asks != holds_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_served++;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(50, 300);
        end
        style_left--;
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 40);
            end
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                          logic [FREQ_W-1:0] f);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_slot_index <= idx;
    in_frequency  <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, idx, f);
    items_sent++;
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic settle();
    pause_input(0);
    while (sb.outcomes_q.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MODE_W+PCOUNT_W-1:0] phase_setting(int p);
    case (p)
      0:       return {MODE_DYNAMIC, 8'd0};
      1:       return {MODE_HYBRID,  8'd0};
      2:       return {MODE_HYBRID,  8'd16};
      3:       return {MODE_HYBRID,  8'd255};
      4:       return {MODE_HYBRID,  8'd15};
      5:       return {MODE_SPARE,   8'd8};
      6:       return {MODE_FIXED,   8'd200};
      7:       return {MODE_HYBRID,  8'd6};
      8:       return {MODE_DYNAMIC, 8'd97};
      default: return {MODE_HYBRID,  8'd3};
    endcase
  endfunction

  task automatic run_phase(int n, bit bursty);
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [FREQ_W-1:0] f;
    int                burst;
    int                r;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      r   = $urandom_range(0, 99);
      idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
      f   = FREQ_W'($urandom());
      if (r < 45)      cmd = OP_REQUEST;
      else if (r < 62) cmd = OP_RELEASE;
      else if (r < 77) cmd = OP_SET_PINNED;
      else if (r < 82) cmd = OP_RESET_DYN;
      else if (r < 88) cmd = OP_QUERY;
      else if (r < 93) cmd = CMD_W'($urandom_range(OP_QUERY + 1, CMD_MAX));
      else begin
        cmd = CMD_W'($urandom());
        idx = IDX_W'($urandom());
      end
      if ($urandom_range(0, 15) == 0) idx = IDX_W'($urandom_range(SLOT_COUNT, IDX_MAX));
      send_cmd(cmd, idx, f);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (bursty) pause_input($urandom_range(0, 20));
      end
      if ($urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    logic [MODE_W+PCOUNT_W-1:0] setting;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = OP_QUERY;
    in_slot_index = '0;
    in_frequency  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_BANK_MODE;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: every slot pinned
    send_cmd(OP_SET_PINNED, 8'd0, 24'h000000);
    send_cmd(OP_SET_PINNED, 8'd15, 24'hFFFFFF);
    send_cmd(OP_SET_PINNED, 8'd0, 24'h5A5A5A);
    send_cmd(OP_REQUEST, 8'd0, 24'h123456);
    send_cmd(OP_SET_PINNED, 8'd16, 24'hFFFFFF);
    send_cmd(OP_RELEASE, 8'd255, 24'h000000);
    send_cmd(OP_RELEASE, 8'd15, 24'hA5A5A5);
    send_cmd(OP_QUERY, 8'd255, 24'hFFFFFF);
    send_cmd(CMD_W'(CMD_MAX), 8'd7, 24'h00FF00);
    send_cmd(OP_RESET_DYN, 8'd0, 24'h000000);
    settle();

    // hybrid with ten pinned: fill the unpinned slots, then evict the oldest twice
    write_cfg(CFG_BANK_MODE, {6'd0, MODE_HYBRID});
    write_cfg(CFG_PINNED_COUNT, 8'd10);
    for (int i = 0; i < SLOT_COUNT - 10 + 2; i++) send_cmd(OP_REQUEST, 8'd0, FREQ_W'($urandom()));
    send_cmd(OP_SET_PINNED, 8'd10, 24'h111111);
    send_cmd(OP_SET_PINNED, 8'd9, 24'h222222);
    send_cmd(OP_RELEASE, 8'd9, 24'h000000);
    send_cmd(OP_RESET_DYN, 8'd0, 24'h000000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      setting = phase_setting(p);
      if (p == 0 || $urandom_range(0, 3) == 0) write_cfg(CFG_SPARE_IDX, CFG_DATA_W'($urandom()));
      if ($urandom_range(0, 1)) begin
        write_cfg(CFG_BANK_MODE, {6'($urandom()), setting[PCOUNT_W +: MODE_W]});
        write_cfg(CFG_PINNED_COUNT, setting[PCOUNT_W-1:0]);
      end else begin
        write_cfg(CFG_PINNED_COUNT, setting[PCOUNT_W-1:0]);
        write_cfg(CFG_BANK_MODE, {6'($urandom()), setting[PCOUNT_W +: MODE_W]});
      end
      if (p == 3 || p == 7) hold_asks++;
      run_phase(PHASE_ITEMS, (p % 3) != 0);
    end

    pause_input(0);
    while (sb.outcomes_q.size() != 0) @(posedge clk);
    repeat (FINAL_WAIT) @(posedge clk);

    $display("Covered %0d transactions over %0d bank settings, %0d results checked.",
             items_sent, NUM_PHASES + 2, sb.checked);
    $display("Saw %0d evictions and %0d rejected requests, with %0d long output stalls.",
             sb.evict_seen, sb.reject_seen, holds_served);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
